FILE: rtl/odr332_pkg.sv
// Package for the RGB332 ordered-dither pixel writer.
// Holds field widths, the transaction layouts, the register file type and register indexes.
// Depends on nothing.
`default_nettype none

package odr332_pkg;

   localparam int ADDR_BITS  = 20;
   localparam int COORD_BITS = 16;

   localparam int DIM_BITS   = 11;
   localparam int BASE_BITS  = 20;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam int CMP_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
   localparam int PROD_BITS = COORD_BITS + DIM_BITS;
   localparam int SUM_TOP  = (ADDR_BITS > PROD_BITS) ? ADDR_BITS : PROD_BITS;
   localparam int SUM_BITS = ((SUM_TOP > BASE_BITS) ? SUM_TOP : BASE_BITS) + 2;

   localparam int REQ_FIELD_BITS = 2 * COORD_BITS + 40;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = ADDR_BITS + 8;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_LAYER_BASE   = 3'd2,
      CSR_DITHER_LOW   = 3'd3,
      CSR_DITHER_HIGH  = 3'd4
   } csr_index_type;

   typedef enum logic {
      FMT_RGB888 = 1'b0,
      FMT_RGB565 = 1'b1
   } fmt_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]  frame_width;
      logic [DIM_BITS-1:0]  frame_height;
      logic [BASE_BITS-1:0] layer_base;
      logic [31:0]          dither_low;
      logic [31:0]          dither_high;
   } cfg_type;

   typedef struct packed {
      logic [15:0]           word565;
      logic [7:0]            blue;
      logic [7:0]            green;
      logic [7:0]            red;
      logic [COORD_BITS-1:0] pos_y;
      logic [COORD_BITS-1:0] pos_x;
   } req_fields_type;

   typedef struct packed {
      logic [7:0]           pixel_value;
      logic [ADDR_BITS-1:0] write_address;
   } rsp_fields_type;

   localparam cfg_type CFG_RESET = '{
      frame_width:  11'd320,
      frame_height: 11'd240,
      layer_base:   20'd0,
      dither_low:   32'd1850516096,
      dither_high:  32'd1568641459
   };

endpackage

`default_nettype wire

FILE: rtl/ordered_dither_to_rgb332.sv
// Top level of the RGB332 ordered-dither pixel writer: register file, input and result registers.
// A pixel passes the input register, then the result register; one pixel per cycle while the
// output is not stalled, with a single bounds/address/dither pass between the two registers.
// Pixels outside the frame are dropped in the input register and free their slot at once.
// Synchronous reset clears both valid flags and loads the register defaults.
// Depends on odr332_pkg and odr332_pixel.
`default_nettype none

module ordered_dither_to_rgb332 (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [odr332_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire  [odr332_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   // low to high: pos_x, pos_y, red, green, blue, word565
   input  wire  [odr332_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // op
   input  wire                                    req_tuser,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   // low to high: write_address, pixel_value, zero pad
   output logic [odr332_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   odr332_pkg::cfg_type        cfg_ff;
   odr332_pkg::cfg_type        cfg_in;
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   odr332_pkg::req_fields_type s1_req_ff;
   odr332_pkg::fmt_type        s1_fmt_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   odr332_pkg::rsp_fields_type rsp_ff;
   odr332_pkg::rsp_fields_type pix_rsp;
   logic                       pix_hit;
   logic                       out_free;
   logic                       s1_advance;
   logic                       req_take;
   logic                       csr_take;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_take) begin
         unique case (csr_index)
            odr332_pkg::CSR_FRAME_WIDTH:
               cfg_in.frame_width  = csr_wdata[odr332_pkg::DIM_BITS-1:0];
            odr332_pkg::CSR_FRAME_HEIGHT:
               cfg_in.frame_height = csr_wdata[odr332_pkg::DIM_BITS-1:0];
            odr332_pkg::CSR_LAYER_BASE:
               cfg_in.layer_base   = csr_wdata[odr332_pkg::BASE_BITS-1:0];
            odr332_pkg::CSR_DITHER_LOW:
               cfg_in.dither_low   = csr_wdata[31:0];
            odr332_pkg::CSR_DITHER_HIGH:
               cfg_in.dither_high  = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   odr332_pixel u_pixel (
      .cfg (cfg_ff),
      .fmt (s1_fmt_ff),
      .req (s1_req_ff),
      .hit (pix_hit),
      .rsp (pix_rsp)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && (!pix_hit || out_free);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = (s1_advance && pix_hit) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= odr332_pkg::CFG_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= odr332_pkg::req_fields_type'(req_tdata[odr332_pkg::REQ_FIELD_BITS-1:0]);
         s1_fmt_ff <= odr332_pkg::fmt_type'(req_tuser);
      end
      if (s1_advance && pix_hit) begin
         rsp_ff <= pix_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = odr332_pkg::RSP_DATA_BITS'(rsp_ff);

endmodule

`default_nettype wire

FILE: rtl/odr332_pixel.sv
// Per-pixel datapath: frame bounds check, address generation and 4x4 ordered dither.
// Purely combinational; uses types and widths from odr332_pkg.
`default_nettype none

module odr332_pixel (
   input  wire odr332_pkg::cfg_type        cfg,
   input  wire odr332_pkg::fmt_type        fmt,
   input  wire odr332_pkg::req_fields_type req,
   output logic                            hit,
   output odr332_pkg::rsp_fields_type      rsp
);

   logic [odr332_pkg::CMP_BITS-1:0]  x_cmp;
   logic [odr332_pkg::CMP_BITS-1:0]  y_cmp;
   logic [odr332_pkg::CMP_BITS-1:0]  w_cmp;
   logic [odr332_pkg::CMP_BITS-1:0]  h_cmp;
   logic [odr332_pkg::PROD_BITS-1:0] row_offset;
   logic [odr332_pkg::SUM_BITS-1:0]  addr_sum;
   logic [63:0]                      matrix;
   logic [3:0]                       entry_idx;
   logic [3:0]                       dither;
   logic [15:0]                      cs;
   logic [7:0]                       hi;
   logic [3:0]                       rr;
   logic [3:0]                       gr;
   logic [3:0]                       br;

   assign x_cmp = odr332_pkg::CMP_BITS'(req.pos_x);
   assign y_cmp = odr332_pkg::CMP_BITS'(req.pos_y);
   assign w_cmp = odr332_pkg::CMP_BITS'(cfg.frame_width);
   assign h_cmp = odr332_pkg::CMP_BITS'(cfg.frame_height);

   assign hit = !req.pos_x[odr332_pkg::COORD_BITS-1] && !req.pos_y[odr332_pkg::COORD_BITS-1]
              && (x_cmp < w_cmp) && (y_cmp < h_cmp);

   assign row_offset = odr332_pkg::PROD_BITS'(req.pos_y) * odr332_pkg::PROD_BITS'(cfg.frame_width);
   assign addr_sum   = odr332_pkg::SUM_BITS'(cfg.layer_base)
                     + odr332_pkg::SUM_BITS'(row_offset)
                     + odr332_pkg::SUM_BITS'(req.pos_x);

   assign matrix    = {cfg.dither_high, cfg.dither_low};
   assign entry_idx = {req.pos_y[1:0], req.pos_x[1:0]};
   assign dither    = matrix[{entry_idx, 2'b00} +: 4];

   assign cs = {req.word565[7:0], req.word565[15:8]};

   always_comb begin
      unique case (fmt)
         odr332_pkg::FMT_RGB888: begin
            hi = {req.red[7:6], 1'b0, req.green[7:6], 1'b0, req.blue[7], 1'b0};
            rr = req.red[5:2];
            gr = req.green[5:2];
            br = req.blue[6:3];
         end
         odr332_pkg::FMT_RGB565: begin
            hi = {cs[15:14], 1'b0, cs[10:9], 1'b0, cs[4], 1'b0};
            rr = {cs[13:11], 1'b0};
            gr = cs[8:5];
            br = cs[3:0];
         end
         default: begin
            hi = '0;
            rr = '0;
            gr = '0;
            br = '0;
         end
      endcase
   end

   assign rsp.write_address = addr_sum[odr332_pkg::ADDR_BITS-1:0];
   assign rsp.pixel_value   = hi | {2'b00, rr > dither, 2'b00, gr > dither, 1'b0, br > dither};

endmodule

`default_nettype wire
